// ===== src/gha_pkg.sv =====
`timescale 1ns / 1ps

package gha_pkg;

   localparam int SLOTS = 1024;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = IDX_W + 1;
   localparam int GEN_W = 32;

   typedef enum logic [1:0] {
      ACT_CREATE   = 2'd0,
      ACT_VALIDATE = 2'd1,
      ACT_FREE     = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [15:0]      slot_index;
      logic [GEN_W-1:0] handle_generation;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [9:0]       result_index;
      logic [GEN_W-1:0] result_generation;
   } rsp_type;

endpackage

// ===== src/gha_ram.sv =====
`timescale 1ns / 1ps

module gha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/generational_handle_allocator.sv =====
`timescale 1ns / 1ps

// Generational slot allocator over 1024 slots. Each request beat gives exactly one
// response beat. Validate, free and create of a never-used slot pass from IDLE
// through EXEC, where the response register is loaded; create that reuses a freed
// slot passes through POP before EXEC, because the popped index must come out of
// the free-stack memory before the generation memory can be read at it. Both
// memories have a registered read, and one request is in flight at a time, so a
// new request beat is accepted only after the last one has left EXEC. A waiting
// response does not block the next request from being accepted. No clearing
// pass is needed after reset: a slot's generation is written to zero when the
// slot is first handed out.
module generational_handle_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gha_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gha_pkg::rsp_type  rsp_data
);

   import gha_pkg::*;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] used_slots_ff, used_slots_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             exec_fire;
   logic [CNT_W-1:0] fc_dec;
   logic             slot_ok;
   logic [GEN_W-1:0] gen_next;

   logic             gen_wr_en;
   logic [IDX_W-1:0] gen_wr_addr;
   logic [GEN_W-1:0] gen_wr_data;
   logic             gen_rd_en;
   logic [IDX_W-1:0] gen_rd_addr;
   logic [GEN_W-1:0] gen_rd_data;

   logic             stk_wr_en;
   logic [IDX_W-1:0] stk_rd_data;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign fc_dec    = free_count_ff - 1'b1;
   assign slot_ok   = 32'(req_ff.slot_index) < 32'(used_slots_ff);
   assign gen_next  = gen_rd_data + 1'b1;

   assign gen_rd_en   = accept || (state_ff == S_POP);
   assign gen_rd_addr = (state_ff == S_POP) ? stk_rd_data : req_data.slot_index[IDX_W-1:0];

   gha_ram #(
      .WIDTH (GEN_W),
      .DEPTH (SLOTS)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_wr_en),
      .wr_addr (gen_wr_addr),
      .wr_data (gen_wr_data),
      .rd_en   (gen_rd_en),
      .rd_addr (gen_rd_addr),
      .rd_data (gen_rd_data)
   );

   gha_ram #(
      .WIDTH (IDX_W),
      .DEPTH (SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (free_count_ff[IDX_W-1:0]),
      .wr_data (req_ff.slot_index[IDX_W-1:0]),
      .rd_en   (accept),
      .rd_addr (fc_dec[IDX_W-1:0]),
      .rd_data (stk_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_count_ff <= '0;
         used_slots_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         used_slots_ff <= used_slots_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      free_count_in = free_count_ff;
      used_slots_in = used_slots_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      gen_wr_en     = 1'b0;
      gen_wr_addr   = req_ff.slot_index[IDX_W-1:0];
      gen_wr_data   = gen_next;
      stk_wr_en     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (req_data.action == ACT_CREATE && free_count_ff != '0) begin
                  state_in = S_POP;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_POP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (exec_fire) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_INVALID, result_index: '0,
                                result_generation: '0};
               case (req_ff.action)
                  ACT_CREATE: begin
                     if (free_count_ff != '0) begin
                        free_count_in = fc_dec;
                        rsp_in = '{status: STATUS_OK, result_index: 10'(stk_rd_data),
                                   result_generation: gen_rd_data};
                     end else if (32'(used_slots_ff) < 32'(SLOTS)) begin
                        used_slots_in = used_slots_ff + 1'b1;
                        gen_wr_en     = 1'b1;
                        gen_wr_addr   = used_slots_ff[IDX_W-1:0];
                        gen_wr_data   = '0;
                        rsp_in = '{status: STATUS_OK,
                                   result_index: 10'(used_slots_ff[IDX_W-1:0]),
                                   result_generation: '0};
                     end else begin
                        rsp_in.status = STATUS_FULL;
                     end
                  end
                  ACT_VALIDATE: begin
                     if (slot_ok && gen_rd_data == req_ff.handle_generation) begin
                        rsp_in = '{status: STATUS_OK,
                                   result_index: 10'(req_ff.slot_index[IDX_W-1:0]),
                                   result_generation: gen_rd_data};
                     end
                  end
                  ACT_FREE: begin
                     if (slot_ok) begin
                        gen_wr_en = 1'b1;
                        rsp_in = '{status: STATUS_OK,
                                   result_index: 10'(req_ff.slot_index[IDX_W-1:0]),
                                   result_generation: gen_next};
                        if (32'(free_count_ff) >= 32'(SLOTS)) begin
                           rsp_in.status = STATUS_FULL;
                        end else begin
                           stk_wr_en     = 1'b1;
                           free_count_in = free_count_ff + 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(free_count_ff) <= 32'(SLOTS) && 32'(used_slots_ff) <= 32'(SLOTS))
      else $error("slot counters out of range");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted beat not taken into work");

   a_exec_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff)
      else $error("finished beat not presented");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP |-> free_count_ff != '0 && req_ff.action == ACT_CREATE)
      else $error("pop from empty free stack");

endmodule
